@@ sv/bsra_pkg.sv @@
package bsra_pkg;

    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_RUN      = 2'd1,
        ST_BAD_COUNT   = 2'd2,
        ST_OUT_OF_POOL = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        logic [0:0]         operation;
        logic [COUNT_W-1:0] slab_count;
        logic [31:0]        free_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slab_index;
        logic [31:0] phys_address;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic wr;
        logic wbit;
    } bm_ctrl_t;

endpackage

@@ sv/bsra_bitmap.sv @@
module bsra_bitmap
    import bsra_pkg::*;
#(
    parameter int SLAB_COUNT = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  bm_ctrl_t ctrl,
    output logic     head
);

    logic [SLAB_COUNT-1:0] map_reg;
    logic [SLAB_COUNT-1:0] map_next;
    logic                  new_bit;

    // rotating line: slab p sits at bit 0 on the p-th shift of a lap
    always_comb
    begin
        new_bit  = ctrl.wr ? ctrl.wbit : map_reg[0];
        map_next = map_reg;
        if (ctrl.shift)
        begin
            map_next = {new_bit, map_reg[SLAB_COUNT-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '1;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

    assign head = map_reg[0];

endmodule

@@ sv/bsra_div.sv @@
module bsra_div
    import bsra_pkg::*;
#(
    parameter int DIVISOR = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] dividend,
    output logic        done,
    output logic [31:0] quotient
);

    localparam int RW = $clog2(DIVISOR);

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [31:0]   q_reg;
    logic [31:0]   q_next;
    logic [4:0]    cnt_reg;
    logic [4:0]    cnt_next;
    logic          active_reg;
    logic          active_next;
    logic          done_reg;
    logic          done_next;
    logic [RW:0]   trial;
    logic          ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial       = {rem_reg, q_reg[31]};
        ge          = trial >= (RW+1)'(DIVISOR);
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (go)
        begin
            rem_next    = '0;
            q_next      = dividend;
            cnt_next    = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            rem_next = ge ? RW'(trial - (RW+1)'(DIVISOR)) : trial[RW-1:0];
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            q_reg      <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            q_reg      <= q_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ sv/bsra_mac.sv @@
module bsra_mac
    import bsra_pkg::*;
#(
    parameter int IDX_W      = 6,
    parameter int SLAB_BYTES = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [31:0]      base,
    input  logic [IDX_W-1:0] index,
    output logic             done,
    output logic [31:0]      addr
);

    localparam int CW = $clog2(IDX_W + 1);

    logic [31:0]      acc_reg;
    logic [31:0]      acc_next;
    logic [31:0]      add_reg;
    logic [31:0]      add_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             active_reg;
    logic             active_next;
    logic             done_reg;
    logic             done_next;

    // base + index * SLAB_BYTES, one index bit per cycle, mod 2^32
    always_comb
    begin
        acc_next    = acc_reg;
        add_next    = add_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (go)
        begin
            acc_next    = base;
            add_next    = 32'(SLAB_BYTES);
            idx_next    = index;
            cnt_next    = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            acc_next = idx_reg[0] ? acc_reg + add_reg : acc_reg;
            add_next = add_reg << 1;
            idx_next = idx_reg >> 1;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(IDX_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            add_reg    <= '0;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            add_reg    <= add_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    assign done = done_reg;
    assign addr = acc_reg;

endmodule

@@ sv/bitmap_slab_run_allocator.sv @@
// Bad counts, zero-count frees and frees below the base: result beat in the cycle after start;
// a scan that finds no run reports once the scan ends; a free past the pool end once the divide ends.
// Allocate: a scan of every slab, a bitmap update, then the address build; free: the divide,
// then the bitmap update.
// One request at a time; the next start is taken in the result beat's cycle; no stall.
// Reset (rst_n, async): every slab free, pool base 0, no beat pending.
module bitmap_slab_run_allocator
    import bsra_pkg::*;
#(
    parameter int SLAB_COUNT = 64,
    parameter int SLAB_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  req_t        request,
    output logic        busy,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output logic        done,
    output rsp_t        result
);

    localparam int IDX_W = $clog2(SLAB_COUNT);
    localparam int END_W = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_APPLY,
        S_MAC
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [31:0]        base_reg;
    logic [31:0]        base_next;
    logic               op_reg;
    logic               op_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [COUNT_W-1:0] run_reg;
    logic [COUNT_W-1:0] run_next;
    logic               found_reg;
    logic               found_next;
    logic [IDX_W-1:0]   lo_reg;
    logic [IDX_W-1:0]   lo_next;
    logic [END_W-1:0]   end_reg;
    logic [END_W-1:0]   end_next;
    logic               done_reg;
    logic               done_next;
    rsp_t               result_reg;
    rsp_t               result_next;

    logic               accept;
    logic               head;
    bm_ctrl_t           bm_ctrl;
    logic               div_go;
    logic               div_done;
    logic [31:0]        div_q;
    logic               mac_go;
    logic               mac_done;
    logic [31:0]        mac_addr;
    logic [COUNT_W-1:0] run_inc;
    logic               found_now;
    logic [IDX_W-1:0]   lo_cur;
    logic               last_pos;
    logic [END_W-1:0]   pos_ext;
    logic               hit;
    logic               q_ok;
    logic [IDX_W+5:0]   lo_wide;

    assign accept  = start && (state_reg == S_IDLE);
    assign run_inc = run_reg + COUNT_W'(1);
    assign last_pos = pos_reg == IDX_W'(SLAB_COUNT - 1);
    assign pos_ext = END_W'(pos_reg);
    assign hit     = (pos_ext >= END_W'(lo_reg)) && (pos_ext < end_reg);
    assign q_ok    = (div_q < 32'(SLAB_COUNT))
                     && ((32'(count_reg) + div_q) <= 32'(SLAB_COUNT));
    assign lo_wide = {6'b0, lo_reg};

    always_comb
    begin
        found_now = !found_reg && head && (run_inc == count_reg);
        lo_cur    = lo_reg;
        if (!found_reg && (run_reg == '0))
        begin
            lo_cur = pos_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        op_next     = op_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        found_next  = found_reg;
        lo_next     = lo_reg;
        end_next    = end_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        div_go      = 1'b0;
        mac_go      = 1'b0;
        bm_ctrl     = '{shift: 1'b0, wr: 1'b0, wbit: op_reg};

        if (cfg_wr_en)
        begin
            base_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = request.operation[0];
                    count_next = request.slab_count;
                    pos_next   = '0;
                    run_next   = '0;
                    found_next = 1'b0;
                    result_next = '0;
                    if (request.operation[0] == OP_ALLOC)
                    begin
                        if ((request.slab_count == '0)
                            || (32'(request.slab_count) > 32'(SLAB_COUNT)))
                        begin
                            result_next.status = ST_BAD_COUNT;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (request.slab_count == '0)
                    begin
                        result_next.status = ST_OK;
                        done_next          = 1'b1;
                    end
                    else if (request.free_address < base_reg)
                    begin
                        result_next.status = ST_OUT_OF_POOL;
                        done_next          = 1'b1;
                    end
                    else
                    begin
                        div_go     = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_SCAN:
            begin
                bm_ctrl.shift = 1'b1;
                pos_next      = pos_reg + IDX_W'(1);
                if (!found_reg)
                begin
                    lo_next  = lo_cur;
                    run_next = head ? run_inc : '0;
                end
                if (found_now)
                begin
                    found_next = 1'b1;
                    end_next   = END_W'(lo_cur) + END_W'(count_reg);
                end
                if (last_pos)
                begin
                    pos_next = '0;
                    if (found_reg || found_now)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        result_next.status = ST_NO_RUN;
                        done_next          = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (q_ok)
                    begin
                        lo_next    = div_q[IDX_W-1:0];
                        end_next   = END_W'(div_q[IDX_W-1:0]) + END_W'(count_reg);
                        pos_next   = '0;
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        result_next.status = ST_OUT_OF_POOL;
                        done_next          = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
            end
            S_APPLY:
            begin
                bm_ctrl.shift = 1'b1;
                bm_ctrl.wr    = hit;
                pos_next      = pos_reg + IDX_W'(1);
                if (last_pos)
                begin
                    pos_next = '0;
                    if (op_reg == OP_ALLOC)
                    begin
                        mac_go     = 1'b1;
                        state_next = S_MAC;
                    end
                    else
                    begin
                        result_next.status     = ST_OK;
                        result_next.slab_index = lo_wide[5:0];
                        done_next              = 1'b1;
                        state_next             = S_IDLE;
                    end
                end
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    result_next.status       = ST_OK;
                    result_next.slab_index   = lo_wide[5:0];
                    result_next.phys_address = mac_addr;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= '0;
            op_reg     <= 1'b0;
            count_reg  <= '0;
            pos_reg    <= '0;
            run_reg    <= '0;
            found_reg  <= 1'b0;
            lo_reg     <= '0;
            end_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            op_reg     <= op_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            run_reg    <= run_next;
            found_reg  <= found_next;
            lo_reg     <= lo_next;
            end_reg    <= end_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    bsra_bitmap #(
        .SLAB_COUNT(SLAB_COUNT)
    ) u_bitmap (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (bm_ctrl),
        .head (head)
    );

    bsra_div #(
        .DIVISOR(SLAB_BYTES)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .dividend(request.free_address - base_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    bsra_mac #(
        .IDX_W     (IDX_W),
        .SLAB_BYTES(SLAB_BYTES)
    ) u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mac_go),
        .base (base_reg),
        .index(lo_reg),
        .done (mac_done),
        .addr (mac_addr)
    );

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_beat_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result beat without a request");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |-> ((result.slab_index == '0)
        && (result.phys_address == '0)))
        else $error("failed request carries nonzero fields");

    a_free_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (op_reg == OP_FREE)) |-> (result.phys_address == '0))
        else $error("free returned an address");

    a_scan_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((count_reg != '0)
        && (32'(count_reg) <= 32'(SLAB_COUNT))))
        else $error("scan started with a bad count");

    a_mac_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_MAC) |-> ($past(state_reg) == S_APPLY))
        else $error("address build not preceded by bitmap update");
`endif

endmodule

@@ dv/slab_grant_checker.sv @@
module slab_grant_checker
    import bsra_pkg::*;
#(
    parameter int SLABS      = 64,
    parameter int SLAB_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  req_t        request,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        done,
    input  rsp_t        result,
    output int          mismatch_count,
    output int          outstanding
);

    logic [SLABS-1:0] free_map;
    logic [31:0]      pool_base;
    rsp_t             expected_grants[$];
    rsp_t             want;
    int               errors;
    int               pushed;
    int               popped;

    function automatic rsp_t next_grant(req_t rq);
        rsp_t        g;
        int unsigned run;
        int unsigned first;
        int unsigned count;
        logic [31:0] offset;
        logic [31:0] slot;
        g     = '0;
        run   = 0;
        first = 0;
        count = rq.slab_count;
        if (op_t'(rq.operation) == OP_ALLOC)
        begin
            if (count == 0 || count > SLABS)
            begin
                g.status = ST_BAD_COUNT;
            end
            else
            begin
                g.status = ST_NO_RUN;
                for (int i = 0; i < SLABS; i++)
                begin
                    if (g.status == ST_NO_RUN)
                    begin
                        if (free_map[i])
                        begin
                            if (run == 0)
                                first = i;
                            run++;
                            if (run == count)
                            begin
                                for (int k = first; k < first + count; k++)
                                    free_map[k] = 1'b0;
                                g.status       = ST_OK;
                                g.slab_index   = first[5:0];
                                g.phys_address = pool_base + 32'(first * SLAB_BYTES);
                            end
                        end
                        else
                        begin
                            run = 0;
                        end
                    end
                end
            end
        end
        else if (count != 0)
        begin
            if (rq.free_address < pool_base)
            begin
                g.status = ST_OUT_OF_POOL;
            end
            else
            begin
                offset = rq.free_address - pool_base;
                slot   = offset / 32'(SLAB_BYTES);
                if (slot >= 32'(SLABS) || 32'(count) > 32'(SLABS) - slot)
                begin
                    g.status = ST_OUT_OF_POOL;
                end
                else
                begin
                    for (int k = slot; k < slot + count; k++)
                        free_map[k] = 1'b1;
                    g.status     = ST_OK;
                    g.slab_index = slot[5:0];
                end
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map = '1;
            pool_base = '0;
            expected_grants.delete();
            errors = 0;
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            pushed = 0;
            popped = 0;
            if (done)
            begin
                if (expected_grants.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result beat: status %0d index %0d addr %h",
                                 result.status, result.slab_index, result.phys_address);
                    errors++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    popped = 1;
                    if (result.status !== want.status
                        || result.slab_index !== want.slab_index
                        || result.phys_address !== want.phys_address)
                    begin
                        if (errors < 10)
                            $display("result mismatch: want status %0d index %0d addr %h,",
                                     want.status, want.slab_index, want.phys_address,
                                     " got status %0d index %0d addr %h",
                                     result.status, result.slab_index, result.phys_address);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_grants.push_back(next_grant(request));
                pushed = 1;
            end
            if (cfg_wr_en)
                pool_base = cfg_wr_data;
            mismatch_count <= errors;
            outstanding <= outstanding + pushed - popped;
        end
    end

endmodule

@@ dv/bitmap_slab_run_allocator_tb.sv @@
module bitmap_slab_run_allocator_tb;
    import bsra_pkg::*;

    localparam int SLABS       = 64;
    localparam int SLAB_BYTES  = 4096;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 140;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    req_t        request = '0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        busy;
    logic        done;
    rsp_t        result;
    int          mismatch_count;
    int          outstanding;

    int          idle_cycles = 0;
    int          calm_left = 0;
    int          n_alloc = 0;
    int          n_free = 0;
    int          n_bases = 0;
    logic [31:0] cur_base = '0;
    logic [31:0] phase_bases[6];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    bitmap_slab_run_allocator #(
        .SLAB_COUNT (SLABS),
        .SLAB_BYTES (SLAB_BYTES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .busy        (busy),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    slab_grant_checker #(
        .SLABS      (SLABS),
        .SLAB_BYTES (SLAB_BYTES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic issue(input op_t op, input int unsigned count, input logic [31:0] addr);
        int unsigned gap;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 30);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 17);
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= {op, count[COUNT_W-1:0], addr};
        do @(posedge clk); while (busy);
        if (op == OP_ALLOC)
            n_alloc++;
        else
            n_free++;
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_pool_base(input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_base = value;
        n_bases++;
    endtask

    function automatic logic [31:0] slab_addr(input int unsigned idx, input int unsigned off);
        return cur_base + 32'(idx * SLAB_BYTES) + 32'(off);
    endfunction

    task automatic random_request();
        int unsigned pick;
        int unsigned idx;
        int unsigned cnt;
        pick = $urandom_range(0, 99);
        idx = $urandom_range(0, SLABS - 1);
        if (pick < 44)
            issue(OP_ALLOC, $urandom_range(1, 6), $urandom());
        else if (pick < 50)
            issue(OP_ALLOC, $urandom_range(7, SLABS), $urandom());
        else if (pick < 53)
            issue(OP_ALLOC, 0, $urandom());
        else if (pick < 56)
            issue(OP_ALLOC, $urandom_range(SLABS + 1, 127), $urandom());
        else if (pick < 84)
        begin
            cnt = $urandom_range(1, 8);
            if (cnt > SLABS - idx)
                cnt = SLABS - idx;
            issue(OP_FREE, cnt, slab_addr(idx, $urandom_range(0, SLAB_BYTES - 1)));
        end
        else if (pick < 87)
            issue(OP_FREE, SLABS, slab_addr(0, $urandom_range(0, SLAB_BYTES - 1)));
        else if (pick < 91)
            issue(OP_FREE, SLABS - idx + $urandom_range(1, 10), slab_addr(idx, 0));
        else if (pick < 94)
            issue(OP_FREE, 0, $urandom());
        else
            issue(OP_FREE, $urandom_range(0, 127), $urandom());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pool_base(32'h1000_0000);
        issue(OP_ALLOC, 1, 32'h0);
        issue(OP_ALLOC, 3, 32'hFFFF_FFFF);
        issue(OP_ALLOC, 0, 32'h0);
        issue(OP_ALLOC, SLABS + 1, 32'h0);
        issue(OP_ALLOC, 127, 32'h0);
        issue(OP_ALLOC, SLABS, 32'h0);
        issue(OP_FREE, 0, slab_addr(5, 0));
        issue(OP_FREE, 1, cur_base - 1);
        issue(OP_FREE, 1, 32'h0);
        issue(OP_FREE, 2, slab_addr(SLABS - 1, 0));
        issue(OP_FREE, 1, slab_addr(SLABS, 0));
        issue(OP_FREE, 127, 32'hFFFF_FFFF);
        issue(OP_FREE, 1, slab_addr(1, SLAB_BYTES - 1));
        issue(OP_FREE, 3, slab_addr(10, 0));
        issue(OP_ALLOC, 60, 32'h0);
        issue(OP_ALLOC, 1, 32'h0);
        issue(OP_FREE, SLABS, slab_addr(0, 0));
        issue(OP_ALLOC, SLABS, 32'h0);
        issue(OP_ALLOC, 1, 32'h0);
        issue(OP_FREE, 32, slab_addr(32, 0));
        issue(OP_ALLOC, 32, 32'h0);
        issue(OP_FREE, SLABS, slab_addr(0, 0));
        settle();

        phase_bases[0] = 32'h0000_0000;
        phase_bases[1] = 32'hFFFF_F000;
        phase_bases[2] = 32'hFFFF_FFFF;
        phase_bases[3] = {20'($urandom_range(0, 32'hF_FFFF)), 12'h000};
        phase_bases[4] = $urandom();
        phase_bases[5] = 32'h8000_0000;
        foreach (phase_bases[p])
        begin
            set_pool_base(phase_bases[p]);
            repeat (PHASE_ITEMS) random_request();
            settle();
        end

        repeat (2 * SLABS + 40) @(posedge clk);
        $display("covered %0d allocate and %0d free requests", n_alloc, n_free);
        $display("across %0d pool base settings, zero and all-ones included", n_bases);
        if (mismatch_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
